### src/assert_macros.svh
// Assertion macros for the SPI master core.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is high.
`define ASSERT_CLK_RST(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

### src/spmp_pkg.sv
// Shared types and constants for the multi-profile SPI master core.
// No dependencies; imported by every module of the block.
`default_nettype none

package spmp_pkg;

  localparam int SLAVE_COUNT   = 4;
  localparam int PROFILE_COUNT = 4;
  localparam int SLAVE_W       = 2;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 6;
  localparam int DIV_W         = 6;
  localparam int HALF_W        = 7;
  localparam int BIT_CNT_W     = 4;

  localparam logic [2:0] MAX_DIV_CODE = 3'd6;
  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef struct packed {
    logic [2:0] code;
    logic       cpha;
    logic       cpol;
    logic       lsb_first;
  } profile_t;

  typedef profile_t [PROFILE_COUNT-1:0] profile_bank_t;

  localparam profile_t PROFILE_RESET = '{code: 3'd0, cpha: 1'b0, cpol: 1'b1, lsb_first: 1'b0};

  typedef struct packed {
    op_t                operation;
    logic [7:0]         tx_byte;
    logic [SLAVE_W-1:0] slave_select;
    logic               last_byte;
    logic               miso;
  } item_t;

  typedef struct packed {
    logic                   sck;
    logic                   mosi;
    logic [SLAVE_COUNT-1:0] cs_n;
    logic [7:0]             rx_byte;
    logic                   rx_valid;
    logic                   transfer_done;
    logic                   busy_res;
    logic                   start_rejected;
  } result_t;

  typedef struct packed {
    logic room;
    logic skid_valid;
  } buf_status_t;

endpackage

`default_nettype wire

### src/spi_master_multi_profile_core.sv
// Top level of the multi-profile SPI master: profiles, engine, result buffer.
// Depends on spmp_pkg, spmp_profiles, spmp_engine, spmp_out_buf, assert_macros.svh.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   operation tx_byte slave_select last_byte miso
//   out      output     out_valid / out_stall sck mosi cs_n rx_byte rx_valid transfer_done
//                                             busy_res start_rejected
//   cfg      input      cfg_write             cfg_index cfg_data
//
// One tick is taken every cycle while in_stall is low; its result passes through
// the input register, then the engine step into the result register.
// The rate is set by the single engine step between the input and result registers.
// Reset loads the profile defaults and idles the engine with SCK high, no select.
// A stalled output fills the skid stage, then in_stall rises; nothing is dropped.
`default_nettype none

`include "assert_macros.svh"

module spi_master_multi_profile_core (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               operation,
  input  wire  [7:0]                        tx_byte,
  input  wire  [spmp_pkg::SLAVE_W-1:0]      slave_select,
  input  wire                               last_byte,
  input  wire                               miso,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              sck,
  output logic                              mosi,
  output logic [spmp_pkg::SLAVE_COUNT-1:0]  cs_n,
  output logic [7:0]                        rx_byte,
  output logic                              rx_valid,
  output logic                              transfer_done,
  output logic                              busy_res,
  output logic                              start_rejected,
  input  wire                               cfg_write,
  input  wire  [spmp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [spmp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spmp_pkg::*;

  profile_bank_t bank;
  item_t         item_in;
  result_t       step_result, out_result;
  buf_status_t   buf_status;
  logic          push;

  assign item_in.operation    = op_t'(operation);
  assign item_in.tx_byte      = tx_byte;
  assign item_in.slave_select = slave_select;
  assign item_in.last_byte    = last_byte;
  assign item_in.miso         = miso;

  spmp_profiles u_profiles (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bank      (bank)
  );

  spmp_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_in    (item_in),
    .bank       (bank),
    .buf_status (buf_status),
    .push       (push),
    .result     (step_result)
  );

  spmp_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .result_in  (step_result),
    .buf_status (buf_status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (out_result)
  );

  assign sck            = out_result.sck;
  assign mosi           = out_result.mosi;
  assign cs_n           = out_result.cs_n;
  assign rx_byte        = out_result.rx_byte;
  assign rx_valid       = out_result.rx_valid;
  assign transfer_done  = out_result.transfer_done;
  assign busy_res       = out_result.busy_res;
  assign start_rejected = out_result.start_rejected;

  `ASSERT_CLK_RST(a_skid_behind_main, clk, rst, buf_status.skid_valid |-> out_valid, "skid stage filled while result register empty")
  `ASSERT_CLK_RST(a_done_with_byte, clk, rst, (out_valid && transfer_done) |-> rx_valid, "transfer done without a received byte")
  `ASSERT_CLK_RST(a_rx_zero_idle, clk, rst, (out_valid && !rx_valid) |-> (rx_byte == 8'd0), "received byte not cleared without rx_valid")
  `ASSERT_CLK_RST(a_one_select, clk, rst, out_valid |-> $onehot0(~cs_n), "more than one slave selected")

endmodule

`default_nettype wire

### src/spmp_profiles.sv
// Per-slave setting profiles written through the configuration port.
// Depends on spmp_pkg.
`default_nettype none

module spmp_profiles (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_write,
  input  wire  [spmp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [spmp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output spmp_pkg::profile_bank_t           bank
);
  import spmp_pkg::*;

  profile_bank_t profiles;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROFILE_COUNT; i++) begin
        profiles[i] <= PROFILE_RESET;
      end
    end else if (cfg_write && (int'(cfg_index) < PROFILE_COUNT)) begin
      // drop writes beyond the last profile
      profiles[cfg_index[SLAVE_W-1:0]] <= profile_t'(cfg_data);
    end
  end

  assign bank = profiles;

endmodule

`default_nettype wire

### src/spmp_engine.sv
// Input register and serial engine state: one tick of the SPI master per item.
// Depends on spmp_pkg.
`default_nettype none

module spmp_engine (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  spmp_pkg::item_t          item_in,
  input  spmp_pkg::profile_bank_t  bank,
  input  spmp_pkg::buf_status_t    buf_status,
  output logic                     push,
  output spmp_pkg::result_t        result
);
  import spmp_pkg::*;

  logic  item_valid;
  item_t item;

  logic [7:0]           out_shift, out_shift_next;
  logic [7:0]           in_shift, in_shift_next;
  logic [DIV_W-1:0]     divider_count, divider_count_next;
  logic [BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic                 second_half, second_half_next;
  logic                 shifting, shifting_next;
  logic [SLAVE_W-1:0]   active_slave, active_slave_next;
  logic                 select_held, select_held_next;
  logic                 final_pending, final_pending_next;
  logic                 clock_level, clock_level_next;

  profile_t             prof, prof_next;
  logic [2:0]           code;
  logic [HALF_W-1:0]    half;
  logic [7:0]           shifted_out, sampled;
  logic [BIT_CNT_W-1:0] bit_count_inc;
  logic                 rx_valid, done, rejected;
  logic [7:0]           rx_byte;

  assign push     = item_valid && buf_status.room;
  assign in_stall = item_valid && !buf_status.room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= item_in;
    end
  end

  always_comb begin
    out_shift_next     = out_shift;
    in_shift_next      = in_shift;
    divider_count_next = divider_count;
    bit_count_next     = bit_count;
    second_half_next   = second_half;
    shifting_next      = shifting;
    active_slave_next  = active_slave;
    select_held_next   = select_held;
    final_pending_next = final_pending;
    clock_level_next   = clock_level;
    rx_valid           = 1'b0;
    rx_byte            = 8'd0;
    done               = 1'b0;
    rejected           = 1'b0;

    prof = bank[active_slave];
    // saturate the divider code
    code = (prof.code > MAX_DIV_CODE) ? MAX_DIV_CODE : prof.code;
    half = HALF_W'(1) << code;
    shifted_out = prof.lsb_first ? {1'b0, out_shift[7:1]} : {out_shift[6:0], 1'b0};
    sampled     = prof.lsb_first ? {item.miso, in_shift[7:1]} : {in_shift[6:0], item.miso};
    bit_count_inc = bit_count + BIT_CNT_W'(1);

    if (shifting) begin
      if (({1'b0, divider_count} + HALF_W'(1)) >= half) begin
        divider_count_next = '0;
        clock_level_next   = ~clock_level;
        if (!second_half) begin
          // leading edge: with cpha set, the first bit is already on the line
          if (prof.cpha) begin
            if (bit_count != '0) begin
              out_shift_next = shifted_out;
            end
          end else begin
            in_shift_next = sampled;
          end
          second_half_next = 1'b1;
        end else begin
          if (prof.cpha) begin
            in_shift_next = sampled;
          end else begin
            out_shift_next = shifted_out;
          end
          second_half_next = 1'b0;
          bit_count_next   = bit_count_inc;
          if (bit_count_inc >= BITS_PER_BYTE) begin
            shifting_next  = 1'b0;
            bit_count_next = '0;
            rx_valid       = 1'b1;
            rx_byte        = in_shift_next;
            if (final_pending) begin
              final_pending_next = 1'b0;
              select_held_next   = 1'b0;
              done               = 1'b1;
            end
          end
        end
      end else begin
        divider_count_next = divider_count + DIV_W'(1);
      end
      if (item.operation == OP_START) begin
        rejected = 1'b1;
      end
    end else if (item.operation == OP_START) begin
      if (int'(item.slave_select) >= SLAVE_COUNT) begin
        rejected = 1'b1;
      end else begin
        active_slave_next  = item.slave_select;
        select_held_next   = 1'b1;
        final_pending_next = item.last_byte;
        out_shift_next     = item.tx_byte;
        in_shift_next      = 8'd0;
        bit_count_next     = '0;
        divider_count_next = '0;
        second_half_next   = 1'b0;
        shifting_next      = 1'b1;
        clock_level_next   = bank[item.slave_select].cpol;
      end
    end
  end

  always_comb begin
    prof_next = bank[active_slave_next];
    result = '0;
    result.sck  = clock_level_next;
    result.mosi = shifting_next &&
                  (prof_next.lsb_first ? out_shift_next[0] : out_shift_next[7]);
    result.cs_n = '1;
    if (select_held_next) begin
      result.cs_n[active_slave_next] = 1'b0;
    end
    result.rx_byte        = rx_byte;
    result.rx_valid       = rx_valid;
    result.transfer_done  = done;
    result.busy_res       = shifting_next;
    result.start_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_shift     <= 8'd0;
      in_shift      <= 8'd0;
      divider_count <= '0;
      bit_count     <= '0;
      second_half   <= 1'b0;
      shifting      <= 1'b0;
      active_slave  <= '0;
      select_held   <= 1'b0;
      final_pending <= 1'b0;
      clock_level   <= 1'b1;
    end else if (push) begin
      out_shift     <= out_shift_next;
      in_shift      <= in_shift_next;
      divider_count <= divider_count_next;
      bit_count     <= bit_count_next;
      second_half   <= second_half_next;
      shifting      <= shifting_next;
      active_slave  <= active_slave_next;
      select_held   <= select_held_next;
      final_pending <= final_pending_next;
      clock_level   <= clock_level_next;
    end
  end

endmodule

`default_nettype wire

### src/spmp_out_buf.sv
// Result register with a skid stage that holds one more engine result under a stall.
// Depends on spmp_pkg.
`default_nettype none

module spmp_out_buf (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  spmp_pkg::result_t      result_in,
  output spmp_pkg::buf_status_t  buf_status,
  output logic                   out_valid,
  input  wire                    out_stall,
  output spmp_pkg::result_t      result_out
);
  import spmp_pkg::*;

  result_t main_q, skid_q;
  logic    main_valid, skid_valid;
  logic    take;

  assign take       = main_valid && !out_stall;
  assign out_valid  = main_valid;
  assign result_out = main_q;

  assign buf_status.room       = !skid_valid;
  assign buf_status.skid_valid = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        main_q <= skid_q;
      end else if (push) begin
        main_q <= result_in;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_q <= result_in;
      end else begin
        main_q <= result_in;
      end
    end
  end

endmodule

`default_nettype wire

### test/spi_master_multi_profile_core_test.sv
// Self-checking testbench for spi_master_multi_profile_core: profile writes, byte transfers,
// rejected starts, slow dividers and live profile changes, with random idling on both sides.
// Depends on spmp_pkg and the core; every result is checked against a local engine model.
`timescale 1ns / 100ps

module spi_master_multi_profile_core_test;
  import spmp_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_PROFILE0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PROFILE1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PROFILE2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PROFILE3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_UNTIL = 1700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OP_TICK;
  logic [7:0] tx_byte = 8'h00;
  logic [SLAVE_W-1:0] slave_select = '0;
  logic last_byte = 1'b0;
  logic miso = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic sck;
  logic mosi;
  logic [SLAVE_COUNT-1:0] cs_n;
  logic [7:0] rx_byte;
  logic rx_valid;
  logic transfer_done;
  logic busy_res;
  logic start_rejected;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  spi_master_multi_profile_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .tx_byte(tx_byte), .slave_select(slave_select),
    .last_byte(last_byte), .miso(miso),
    .out_valid(out_valid), .out_stall(out_stall),
    .sck(sck), .mosi(mosi), .cs_n(cs_n), .rx_byte(rx_byte), .rx_valid(rx_valid),
    .transfer_done(transfer_done), .busy_res(busy_res), .start_rejected(start_rejected),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Engine model state
  profile_t prof_bank [PROFILE_COUNT];
  logic [7:0] out_sr;
  logic [7:0] in_sr;
  logic [DIV_W-1:0] div_cnt;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic second_half;
  logic eng_busy;
  logic [SLAVE_W-1:0] act_slave;
  logic select_held;
  logic final_pending;
  logic clk_level;

  result_t pending_pins [$];
  int errors = 0;
  int ticks_sent = 0;
  int idle_odds = 8;
  int cycle_count = 0;
  bit driving = 1'b0;

  // Advance the engine model by one tick and return the pin state after it.
  function automatic result_t step_engine(input op_t op, input logic [7:0] tx,
                                          input logic [SLAVE_W-1:0] sel, input logic last,
                                          input logic miso_bit);
    result_t r;
    profile_t p;
    logic [2:0] code;
    logic [HALF_W-1:0] half;
    r = '0;
    if (eng_busy) begin
      p = prof_bank[act_slave];
      code = (p.code > MAX_DIV_CODE) ? MAX_DIV_CODE : p.code;
      half = 7'd1 << code;
      if ({1'b0, div_cnt} + 7'd1 >= half) begin
        div_cnt = '0;
        clk_level = ~clk_level;
        if (!second_half) begin
          // leading edge: cpha 1 shifts (not before the first bit), cpha 0 samples
          if (p.cpha) begin
            if (bit_cnt != 0) out_sr = p.lsb_first ? out_sr >> 1 : out_sr << 1;
          end else begin
            in_sr = p.lsb_first ? {miso_bit, in_sr[7:1]} : {in_sr[6:0], miso_bit};
          end
          second_half = 1'b1;
        end else begin
          if (p.cpha) in_sr = p.lsb_first ? {miso_bit, in_sr[7:1]} : {in_sr[6:0], miso_bit};
          else out_sr = p.lsb_first ? out_sr >> 1 : out_sr << 1;
          second_half = 1'b0;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= BITS_PER_BYTE) begin
            eng_busy = 1'b0;
            bit_cnt = '0;
            r.rx_valid = 1'b1;
            r.rx_byte = in_sr;
            if (final_pending) begin
              final_pending = 1'b0;
              select_held = 1'b0;
              r.transfer_done = 1'b1;
            end
          end
        end
      end else begin
        div_cnt = div_cnt + 6'd1;
      end
      if (op == OP_START) r.start_rejected = 1'b1;
    end else if (op == OP_START) begin
      act_slave = sel;
      select_held = 1'b1;
      final_pending = last;
      out_sr = tx;
      in_sr = '0;
      bit_cnt = '0;
      div_cnt = '0;
      second_half = 1'b0;
      eng_busy = 1'b1;
      clk_level = prof_bank[sel].cpol;
    end
    r.cs_n = '1;
    if (select_held) r.cs_n[act_slave] = 1'b0;
    r.sck = clk_level;
    r.mosi = eng_busy ? (prof_bank[act_slave].lsb_first ? out_sr[0] : out_sr[7]) : 1'b0;
    r.busy_res = eng_busy;
    return r;
  endfunction

  task automatic send_tick(input op_t op, input logic [7:0] tx, input logic [SLAVE_W-1:0] sel,
                           input logic last, input logic miso_bit);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      if (driving) in_valid <= 1'b0;
      driving = 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    driving = 1'b1;
    operation <= op;
    tx_byte <= tx;
    slave_select <= sel;
    last_byte <= last;
    miso <= miso_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pins.push_back(step_engine(op, tx, sel, last, miso_bit));
    ticks_sent++;
  endtask

  // Hold the input channel quiet until every result has come back.
  task automatic drain;
    if (driving) in_valid <= 1'b0;
    driving = 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx < PROFILE_COUNT) prof_bank[idx[SLAVE_W-1:0]] = profile_t'(data);
  endtask

  task automatic send_noise;
    send_tick(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // One well-formed byte with random content and the odd start thrown in mid-byte.
  task automatic run_byte(input logic [SLAVE_W-1:0] sel, input logic [7:0] tx, input logic last);
    send_tick(OP_START, tx, sel, last, 1'($urandom_range(0, 1)));
    while (eng_busy) begin
      if ($urandom_range(0, 40) == 0) send_noise();
      else send_tick(OP_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_select_handover;
    // spare indexes must leave the profiles alone
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      write_reg(CFG_INDEX_W'(i), 6'h3F);
    send_tick(OP_START, 8'h00, 2'd0, 1'b0, 1'b1);
    while (eng_busy) send_tick(OP_TICK, 8'hFF, 2'd3, 1'b1, 1'b1);
    // new slave while slave 0 is still held, then a start that must bounce
    send_tick(OP_START, 8'hFF, 2'd3, 1'b1, 1'b0);
    send_tick(OP_START, 8'h5A, 2'd1, 1'b0, 1'b0);
    while (eng_busy) send_tick(OP_TICK, 8'h00, 2'd0, 1'b0, 1'b0);
    send_tick(OP_TICK, 8'hA5, 2'd2, 1'b1, 1'b1);
  endtask

  task automatic test_slow_divider;
    drain();
    write_reg(REG_PROFILE1, 6'd55);
    write_reg(REG_PROFILE2, 6'd63);
    run_byte(2'd1, 8'($urandom_range(0, 255)), 1'b1);
    // divider code 7 saturates; switch the profile mid-byte to finish quickly
    send_tick(OP_START, 8'($urandom_range(0, 255)), 2'd2, 1'b0, 1'($urandom_range(0, 1)));
    repeat (300) send_tick(OP_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    drain();
    write_reg(REG_PROFILE2, 6'd6);
    while (eng_busy) send_tick(OP_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_traffic;
    int phase;
    int odds_pick;
    logic [2:0] code;
    phase = 0;
    while (ticks_sent < RANDOM_UNTIL) begin
      drain();
      for (int i = REG_PROFILE0; i <= REG_PROFILE3; i++) begin
        code = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(3, 5)) : 3'($urandom_range(0, 2));
        if (phase == 0) write_reg(CFG_INDEX_W'(i), 6'd0);
        else if (phase == 1) write_reg(CFG_INDEX_W'(i), 6'd7);
        else write_reg(CFG_INDEX_W'(i), {code, 3'($urandom_range(0, 7))});
      end
      odds_pick = $urandom_range(0, 3);
      idle_odds = (odds_pick == 0) ? 0 : (odds_pick == 1) ? 3 : (odds_pick == 2) ? 8 : 20;
      repeat ($urandom_range(4, 10)) begin
        if (ticks_sent < RANDOM_UNTIL) begin
          if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) send_noise();
          else run_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        $urandom_range(0, 2) == 0);
        end
      end
      phase++;
    end
  endtask

  task automatic test_calm_finish;
    drain();
    idle_odds = 0;
    write_reg(REG_PROFILE3, 6'd13);
    repeat (3) run_byte(2'd3, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_out
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pins.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected transaction: expected none, got rx_byte %0h", $time, rx_byte);
      end else begin
        want = pending_pins.pop_front();
        check_field("sck", 8'(want.sck), 8'(sck));
        check_field("mosi", 8'(want.mosi), 8'(mosi));
        check_field("cs_n", 8'(want.cs_n), 8'(cs_n));
        check_field("rx_byte", want.rx_byte, rx_byte);
        check_field("rx_valid", 8'(want.rx_valid), 8'(rx_valid));
        check_field("transfer_done", 8'(want.transfer_done), 8'(transfer_done));
        check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
        check_field("start_rejected", 8'(want.start_rejected), 8'(start_rejected));
      end
    end
  end

  // Receiver stalls in random bursts while idling is allowed.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && idle_odds != 0 && $urandom_range(1, idle_odds + 8) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("spi_master_multi_profile_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < PROFILE_COUNT; i++) prof_bank[i] = PROFILE_RESET;
    out_sr = '0;
    in_sr = '0;
    div_cnt = '0;
    bit_cnt = '0;
    second_half = 1'b0;
    eng_busy = 1'b0;
    act_slave = '0;
    select_held = 1'b0;
    final_pending = 1'b0;
    clk_level = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_select_handover();
    test_slow_divider();
    test_random_traffic();
    test_calm_finish();
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("spi_master_multi_profile_core_test OK");
    else $display("spi_master_multi_profile_core_test NOT OK");
    $finish;
  end

endmodule
